// ===== rtl/bfs_pkg.sv =====
package bfs_pkg;

   // hash word and multipliers
   localparam int HASH_W = 32;
   localparam logic [HASH_W-1:0] MULT_FIRST  = 32'd17;
   localparam logic [HASH_W-1:0] MULT_SECOND = 32'd29;

   // configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_SIZE  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANY_HIT_MODE = 8'd1;
   localparam int FILTER_SIZE_RESET = 4096;

   // defaults and fixed sizes
   localparam int FILTER_BITS_DEF = 4096;
   localparam int QUEUE_DEPTH     = 2;

   // operation codes
   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // one finished string, handed from front to back
   typedef struct packed {
      logic              func;
      logic [HASH_W-1:0] hash_first;
      logic [HASH_W-1:0] hash_second;
   } bfs_job_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_WR_A,
      ST_WR_B,
      ST_RD_A,
      ST_RD_B,
      ST_RD_DONE
   } bfs_back_state_type;

endpackage

// ===== rtl/bfs_ram.sv =====
module bfs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bfs_queue.sv =====
module bfs_queue import bfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  bfs_job_type push_job,
   input  logic        pop,
   output bfs_job_type head_job,
   output logic        empty,
   output logic        full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bfs_job_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_job = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/bfs_front.sv =====
module bfs_front import bfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_char_byte,
   input  logic        clearing,
   input  logic        queue_full,
   output logic        push,
   output bfs_job_type push_job
);

   logic [HASH_W-1:0] hash_first_ff, hash_first_in;
   logic [HASH_W-1:0] hash_second_ff, hash_second_in;
   logic [HASH_W-1:0] char_ext;
   logic              accept;
   logic              is_term;

   assign req_ready = !clearing && !queue_full;
   assign accept    = req_valid && req_ready;
   assign is_term   = (req_char_byte == 8'd0);

   // byte taken as a signed char
   assign char_ext = {{(HASH_W - 8){req_char_byte[7]}}, req_char_byte};

   // terminator hands the finished hashes to the back end
   assign push                 = accept && is_term;
   assign push_job.func        = req_func;
   assign push_job.hash_first  = hash_first_ff;
   assign push_job.hash_second = hash_second_ff;

   // hash update, restart after each terminator
   always_comb begin
      hash_first_in  = hash_first_ff;
      hash_second_in = hash_second_ff;
      if (accept) begin
         if (is_term) begin
            hash_first_in  = '0;
            hash_second_in = '0;
         end else begin
            hash_first_in  = hash_first_ff * MULT_FIRST + char_ext;
            hash_second_in = hash_second_ff * MULT_SECOND + char_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_first_ff  <= '0;
         hash_second_ff <= '0;
      end else begin
         hash_first_ff  <= hash_first_in;
         hash_second_ff <= hash_second_in;
      end
   end

endmodule

// ===== rtl/bfs_back.sv =====
module bfs_back import bfs_pkg::*; #(
   parameter int FILTER_BITS = FILTER_BITS_DEF,
   parameter int SZ_W        = $clog2(FILTER_BITS + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            queue_empty,
   input  bfs_job_type     head_job,
   output logic            pop,
   input  logic [SZ_W-1:0] size,
   input  logic            any_hit_mode,
   output logic            clearing,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_is_member
);

   localparam int IDX_W = $clog2(FILTER_BITS);
   localparam int CNT_W = $clog2(HASH_W);

   bfs_back_state_type state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic               func_ff, func_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [HASH_W-1:0]  quo_ff [2];
   logic [HASH_W-1:0]  quo_in [2];
   logic [SZ_W-1:0]    rem_ff [2];
   logic [SZ_W-1:0]    rem_in [2];
   logic [SZ_W-1:0]    rem_step [2];
   logic [HASH_W-1:0]  mag [2];
   logic               hit_a_ff, hit_a_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_member_ff, rsp_member_in;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic               ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic               ram_rd_data;
   logic [IDX_W-1:0]   idx_a;
   logic [IDX_W-1:0]   idx_b;

   assign clearing      = (state_ff == ST_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_member = rsp_member_ff;
   assign idx_a         = rem_ff[0][IDX_W-1:0];
   assign idx_b         = rem_ff[1][IDX_W-1:0];

   // magnitude of the signed hash; the most negative value stays 2^31 unsigned
   assign mag[0] = head_job.hash_first[HASH_W-1]  ? (~head_job.hash_first + 1'b1)
                                                  : head_job.hash_first;
   assign mag[1] = head_job.hash_second[HASH_W-1] ? (~head_job.hash_second + 1'b1)
                                                  : head_job.hash_second;

   // one restoring remainder step per lane
   always_comb begin
      logic [SZ_W:0] trial;
      for (int i = 0; i < 2; i++) begin
         trial = {rem_ff[i], quo_ff[i][HASH_W-1]};
         if (trial >= {1'b0, size}) begin
            rem_step[i] = SZ_W'(trial - {1'b0, size});
         end else begin
            rem_step[i] = trial[SZ_W-1:0];
         end
      end
   end

   bfs_ram #(
      .WIDTH(1),
      .DEPTH(FILTER_BITS)
   ) u_filter_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // sequencer: clear pass, modulo, then bit writes or bit reads
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      func_in       = func_ff;
      cnt_in        = cnt_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      hit_a_in      = hit_a_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_member_in = rsp_member_ff;
      pop           = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_a;
      ram_wr_data   = 1'b1;
      ram_rd_addr   = idx_a;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = 1'b0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(FILTER_BITS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               pop       = 1'b1;
               func_in   = head_job.func;
               quo_in[0] = mag[0];
               quo_in[1] = mag[1];
               rem_in[0] = '0;
               rem_in[1] = '0;
               cnt_in    = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            for (int i = 0; i < 2; i++) begin
               rem_in[i] = rem_step[i];
               quo_in[i] = {quo_ff[i][HASH_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(HASH_W - 1)) begin
               state_in = (func_ff == FUNC_ADD) ? ST_WR_A : ST_RD_A;
            end
         end
         ST_WR_A: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_a;
            state_in    = ST_WR_B;
         end
         ST_WR_B: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_b;
            state_in    = ST_IDLE;
         end
         ST_RD_A: begin
            ram_rd_addr = idx_a;
            state_in    = ST_RD_B;
         end
         ST_RD_B: begin
            ram_rd_addr = idx_b;
            hit_a_in    = ram_rd_data;
            state_in    = ST_RD_DONE;
         end
         ST_RD_DONE: begin
            // read data of the second bit holds while the output word waits
            ram_rd_addr = idx_b;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_member_in = any_hit_mode ? (hit_a_ff || ram_rd_data)
                                            : (hit_a_ff && ram_rd_data);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      cnt_ff        <= cnt_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      hit_a_ff      <= hit_a_in;
      rsp_member_ff <= rsp_member_in;
   end

endmodule

// ===== rtl/bloom_filter_string_two_hash_core.sv =====
// Two-hash Bloom filter over zero-terminated byte strings. Bytes enter one per
// cycle on the req_ channel while req_ready is high; each nonzero byte steps both
// 32-bit hashes (x17 and x29, byte sign-extended) in the front end. A zero byte
// ends the string: its func selects add (set both bits, no response) or lookup
// (one response word on rsp_, AND of the two bits, or OR when any_hit_mode is
// set). Terminators wait in a two-entry queue for the back end, which takes one
// string at a time, reduces both hash magnitudes modulo filter_size with a
// bit-serial remainder unit, then writes both bits for an add, or reads both bits
// and forms the response word for a lookup; req_ready drops while the queue is full.
// After reset the bit store is cleared, one bit per cycle; req_ready stays low
// during that pass. csr_ writes are always accepted and should be issued while
// the block is idle; filter_size 0 acts as 1 and values above FILTER_BITS are
// clipped.
module bloom_filter_string_two_hash_core import bfs_pkg::*; #(
   parameter int FILTER_BITS = FILTER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic [7:0]             req_char_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_member,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SZ_W = $clog2(FILTER_BITS + 1);
   localparam int SIZE_RESET = (FILTER_SIZE_RESET > FILTER_BITS) ? FILTER_BITS
                                                                 : FILTER_SIZE_RESET;

   logic [SZ_W-1:0] size_ff, size_in;
   logic            any_hit_ff, any_hit_in;
   logic            clearing;
   logic            queue_full;
   logic            queue_empty;
   logic            push;
   logic            pop;
   bfs_job_type     push_job;
   bfs_job_type     head_job;

   assign csr_ready = 1'b1;

   // register writes; size is kept already clipped to 1..FILTER_BITS
   always_comb begin
      size_in    = size_ff;
      any_hit_in = any_hit_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FILTER_SIZE: begin
               if (csr_data == '0) begin
                  size_in = SZ_W'(1);
               end else if (32'(csr_data) > 32'(FILTER_BITS)) begin
                  size_in = SZ_W'(FILTER_BITS);
               end else begin
                  size_in = SZ_W'(csr_data);
               end
            end
            CSR_ANY_HIT_MODE: begin
               any_hit_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= SZ_W'(SIZE_RESET);
         any_hit_ff <= 1'b0;
      end else begin
         size_ff    <= size_in;
         any_hit_ff <= any_hit_in;
      end
   end

   bfs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_char_byte(req_char_byte),
      .clearing     (clearing),
      .queue_full   (queue_full),
      .push         (push),
      .push_job     (push_job)
   );

   bfs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .head_job(head_job),
      .empty   (queue_empty),
      .full    (queue_full)
   );

   bfs_back #(
      .FILTER_BITS(FILTER_BITS),
      .SZ_W       (SZ_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_empty  (queue_empty),
      .head_job     (head_job),
      .pop          (pop),
      .size         (size_ff),
      .any_hit_mode (any_hit_ff),
      .clearing     (clearing),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_member(rsp_is_member)
   );

endmodule

// ===== tb/bfs_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, response and register channels of the Bloom filter core.
// Keeps its own hashes, bit store and register copies, predicts every lookup
// answer and compares it against the response word.
module bfs_checker import bfs_pkg::*; #(
   parameter int FILTER_BITS = FILTER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_func,
   input  logic [7:0]             req_char_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_is_member,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pend_count
);

   // predictor state
   logic [HASH_W-1:0]     hash_x17;
   logic [HASH_W-1:0]     hash_x29;
   logic                  filter_set [FILTER_BITS];
   logic [CSR_DATA_W-1:0] size_reg;
   logic                  any_hit;
   logic                  member_q [$];
   int                    fails;

   // magnitude of the signed hash, reduced by the clipped filter size
   function automatic int bit_index(input logic [HASH_W-1:0] h,
                                    input logic [CSR_DATA_W-1:0] size);
      logic [HASH_W-1:0] mag;
      int unsigned       modulus;
      mag = h[HASH_W-1] ? (~h + 1'b1) : h;
      if (size == 0)
         modulus = 1;
      else if (size > FILTER_BITS)
         modulus = FILTER_BITS;
      else
         modulus = size;
      return int'(mag % modulus);
   endfunction

   // one accepted string byte or terminator
   task automatic take_word(input logic func, input logic [7:0] ch);
      logic [HASH_W-1:0] c;
      int                idx_a;
      int                idx_b;
      c = {{(HASH_W-8){ch[7]}}, ch};
      if (ch != 8'd0) begin
         hash_x17 = hash_x17 * MULT_FIRST + c;
         hash_x29 = hash_x29 * MULT_SECOND + c;
      end else begin
         idx_a = bit_index(hash_x17, size_reg);
         idx_b = bit_index(hash_x29, size_reg);
         hash_x17 = '0;
         hash_x29 = '0;
         if (func == FUNC_ADD) begin
            filter_set[idx_a] = 1'b1;
            filter_set[idx_b] = 1'b1;
         end else if (any_hit) begin
            member_q.push_back(filter_set[idx_a] | filter_set[idx_b]);
         end else begin
            member_q.push_back(filter_set[idx_a] & filter_set[idx_b]);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hash_x17 = '0;
         hash_x29 = '0;
         for (int i = 0; i < FILTER_BITS; i++)
            filter_set[i] = 1'b0;
         size_reg = CSR_DATA_W'(FILTER_SIZE_RESET);
         any_hit  = 1'b0;
         member_q.delete();
         fails = 0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FILTER_SIZE:  size_reg = csr_data;
               CSR_ANY_HIT_MODE: any_hit = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            take_word(req_func, req_char_byte);
         // response compare against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (member_q.size() == 0) begin
               $display("%0t: unexpected is_member word, expected none, actual %0b",
                        $time, rsp_is_member);
               fails++;
            end else begin
               if (rsp_is_member !== member_q[0]) begin
                  $display("%0t: is_member mismatch, expected %0b, actual %0b",
                           $time, member_q[0], rsp_is_member);
                  fails++;
               end
               void'(member_q.pop_front());
            end
         end
      end
      fail_count <= fails;
      pend_count <= member_q.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench import bfs_pkg::*;;

   localparam int FILTER_BITS = FILTER_BITS_DEF;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [4:0]       len;
      logic [15:0][7:0] text;
   } text_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_func = 1'b0;
   logic [7:0]             req_char_byte = 8'd0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_is_member;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   int                     fail_count;
   int                     pend_count;
   int                     burst_left = 0;
   int                     ready_run = 0;
   int                     stall_run = 0;
   int                     cycles = 0;
   text_type               added_q [$];

   bloom_filter_string_two_hash_core #(.FILTER_BITS(FILTER_BITS)) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_char_byte (req_char_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_member (rsp_is_member),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   bfs_checker #(.FILTER_BITS(FILTER_BITS)) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_char_byte (req_char_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_member (rsp_is_member),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pend_count    (pend_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side: ready runs broken by stalls of random length
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_run <= 0;
         stall_run <= 0;
      end else if (stall_run > 0) begin
         rsp_ready <= 1'b0;
         stall_run <= stall_run - 1;
      end else if (ready_run > 0) begin
         rsp_ready <= 1'b1;
         ready_run <= ready_run - 1;
      end else begin
         rsp_ready <= 1'b1;
         ready_run <= $urandom_range(0, 40);
         stall_run <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      end
   end

   // one request word, with bursts and gaps on the sender side
   task automatic send_word(input logic func, input logic [7:0] ch);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
         gap = $urandom_range(1, 8);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_char_byte <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // string bytes carry a random func, which the block ignores
   task automatic send_text(input text_type t, input logic func);
      for (int k = 0; k < t.len; k++)
         send_word(1'($urandom_range(0, 1)), t.text[k]);
      send_word(func, 8'd0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] size, input logic any_hit);
      write_reg(CSR_FILTER_SIZE, size);
      write_reg(CSR_ANY_HIT_MODE, CSR_DATA_W'(any_hit));
      csr_valid <= 1'b0;
   endtask

   // drop valid, wait for all lookups to answer, then let queued adds finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pend_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // string whose hash with this multiplier lands exactly on -2^31
   function automatic text_type text_for_min_hash(input int mult);
      int       digit [$];
      longint   v;
      text_type t;
      v = 64'h8000_0000;
      t = '0;
      while (v > 0) begin
         digit.push_back(int'(v % mult));
         v = v / mult;
      end
      // zero digits would end the string: borrow from the next digit up
      for (int i = 0; i < digit.size() - 1; i++) begin
         if (digit[i] == 0) begin
            digit[i] = mult;
            digit[i+1] = digit[i+1] - 1;
         end
      end
      while (digit[digit.size()-1] == 0) void'(digit.pop_back());
      t.len = 5'(digit.size());
      for (int k = 0; k < digit.size(); k++)
         t.text[k] = 8'(digit[digit.size()-1-k]);
      return t;
   endfunction

   // mixed adds, lookups of stored strings and lookups of fresh strings
   task automatic run_phase(input int strings);
      text_type t;
      logic     func;
      for (int s = 0; s < strings; s++) begin
         if (added_q.size() > 0 && $urandom_range(0, 2) == 0) begin
            t = added_q[$urandom_range(0, added_q.size() - 1)];
            func = FUNC_LOOKUP;
         end else begin
            t = '0;
            if ($urandom_range(0, 19) == 0)
               t.len = 0;
            else if ($urandom_range(0, 7) == 0)
               t.len = 5'($urandom_range(7, 15));
            else
               t.len = 5'($urandom_range(1, 6));
            for (int k = 0; k < 16; k++)
               t.text[k] = 8'($urandom_range(1, 255));
            func = ($urandom_range(0, 1) == 0) ? FUNC_ADD : FUNC_LOOKUP;
         end
         if (func == FUNC_ADD)
            added_q.push_back(t);
         send_text(t, func);
      end
      wait_idle();
   endtask

   initial begin
      text_type t;
      t = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty string before and after an add, byte extremes
      send_text(t, FUNC_LOOKUP);
      send_text(t, FUNC_ADD);
      send_text(t, FUNC_LOOKUP);
      t.len = 5;
      t.text[0] = 8'h7f;
      t.text[1] = 8'h80;
      t.text[2] = 8'hff;
      t.text[3] = 8'h01;
      t.text[4] = 8'hc3;
      send_text(t, FUNC_LOOKUP);
      send_text(t, FUNC_ADD);
      send_text(t, FUNC_LOOKUP);
      added_q.push_back(t);
      wait_idle();

      // hashes that hit the most negative value, then lookups later on
      set_config(CSR_DATA_W'(FILTER_SIZE_RESET), 1'b0);
      t = text_for_min_hash(17);
      send_text(t, FUNC_ADD);
      added_q.push_back(t);
      t = text_for_min_hash(29);
      send_text(t, FUNC_LOOKUP);
      send_text(t, FUNC_ADD);
      added_q.push_back(t);
      run_phase(25);

      // sweep of sizes and hit modes; the bit store carries over
      set_config(13'd1, 1'b0);
      run_phase(15);
      set_config(13'd0, 1'b1);
      run_phase(15);
      set_config(13'd8191, 1'b0);
      run_phase(20);
      set_config(13'd2, 1'b1);
      run_phase(15);
      set_config(13'd4095, 1'b1);
      run_phase(20);
      set_config(13'd97, 1'b0);
      run_phase(20);
      set_config(13'($urandom_range(1, 300)), 1'($urandom_range(0, 1)));
      run_phase(20);
      set_config(13'd4096, 1'b1);
      run_phase(20);

      if (fail_count == 0 && pend_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
